### design/assert_macros.svh
// Assertion macros used by the checker file of the cache.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define LKVC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lkvc: assertion failed");

// Clocked assertion that also holds during reset.
`define LKVC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lkvc: assertion failed");

`endif

### design/lkvc_pkg.sv
// Package for the LRU key/value cache: widths, codes, state and result types.
// No dependencies.
package lkvc_pkg;

  localparam int unsigned DefEntries = 16;
  localparam int unsigned MinCap     = 8;
  localparam int unsigned CapW       = 5;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned DataW      = 64;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } lkvc_kind_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_INVALID = 1'b1
  } lkvc_status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPDATE_END,
    ST_FINISH
  } lkvc_state_e;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] read_value;
    logic             status;
  } lkvc_result_t;

endpackage

### design/lkvc_intf.sv
// Request and response channel interfaces (valid/ready) of the cache.
// Depends on lkvc_pkg.
interface lkvc_req_if import lkvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [KeyW-1:0]  key_tag;
  logic [DataW-1:0] data_word;

  modport source (output valid, output kind, output key_tag, output data_word, input ready);
  modport sink   (input valid, input kind, input key_tag, input data_word, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [DataW-1:0] read_value;
  logic             status;

  modport source (output valid, output hit, output read_value, output status, input ready);
  modport sink   (input valid, input hit, input read_value, input status, output ready);
endinterface

### design/lkvc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lkvc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lkvc_ctrl.sv
// Cache sequencer: tag scan, replacement decision and recency rewrite pass.
// Depends on lkvc_pkg; drives the tag/rank RAM and the value RAM.
module lkvc_ctrl import lkvc_pkg::*; #(
  parameter int unsigned Entries = DefEntries
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CapW-1:0]               cfg_wdata_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic                          req_kind_i,
  input  logic [KeyW-1:0]               req_key_i,
  input  logic [DataW-1:0]              req_data_i,
  output logic                          tag_we_o,
  output logic [$clog2(Entries)-1:0]    tag_waddr_o,
  output logic [KeyW+$clog2(Entries)-1:0] tag_wdata_o,
  output logic                          tag_re_o,
  output logic [$clog2(Entries)-1:0]    tag_raddr_o,
  input  logic [KeyW+$clog2(Entries)-1:0] tag_rdata_i,
  output logic                          val_we_o,
  output logic [$clog2(Entries)-1:0]    val_waddr_o,
  output logic [DataW-1:0]              val_wdata_o,
  output logic                          val_re_o,
  output logic [$clog2(Entries)-1:0]    val_raddr_o,
  input  logic [DataW-1:0]              val_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output lkvc_result_t                  res_o
);

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Entries - 1);

  lkvc_state_e state_q, state_d;

  logic [CapW-1:0]  cap_q;
  logic [CntW-1:0]  count_q;
  logic [Entries-1:0] valid_q;

  logic             kind_q;
  logic [KeyW-1:0]  key_q;
  logic [DataW-1:0] data_q;
  logic             zero_put_q;

  logic [IdxW-1:0]  rd_idx_q;
  logic             cmp_vld_q;
  logic [IdxW-1:0]  cmp_idx_q;

  logic             hit_q;
  logic [IdxW-1:0]  hit_idx_q;
  logic [IdxW-1:0]  hit_rank_q;
  logic             vic_q;
  logic [IdxW-1:0]  vic_idx_q;
  logic [IdxW-1:0]  vic_rank_q;
  logic             free_q;
  logic [IdxW-1:0]  free_idx_q;
  logic [IdxW-1:0]  slot_q;
  logic             touch_q;

  logic             accept;
  logic             issue;
  logic             scanning;
  logic             updating;
  logic             evict;
  logic [IdxW-1:0]  new_slot;
  logic [CmpW-1:0]  eff_cap;
  logic [CmpW-1:0]  cap_ext;
  logic [IdxW-1:0]  old_rank;
  logic [KeyW-1:0]  old_key;
  logic [IdxW-1:0]  upd_rank;
  logic [Entries-1:0] vic_mask;
  logic [Entries-1:0] slot_mask;

  assign accept   = req_valid_i && (state_q == ST_IDLE);
  assign issue    = (state_q == ST_SCAN) || (state_q == ST_UPDATE);
  assign scanning = cmp_vld_q && ((state_q == ST_SCAN) || (state_q == ST_SCAN_END));
  assign updating = cmp_vld_q && ((state_q == ST_UPDATE) || (state_q == ST_UPDATE_END));

  // Effective capacity: register clamped into [MinCap, Entries].
  assign cap_ext = CmpW'(cap_q);
  always_comb begin
    eff_cap = cap_ext;
    if (cap_ext < CmpW'(MinCap)) begin
      eff_cap = CmpW'(MinCap);
    end
    if (cap_ext > CmpW'(Entries)) begin
      eff_cap = CmpW'(Entries);
    end
  end

  assign evict = CmpW'(count_q) >= eff_cap;

  // First free slot after eviction: the victim may sit below the first free one.
  always_comb begin
    new_slot = free_idx_q;
    if (evict) begin
      new_slot = (free_q && (free_idx_q < vic_idx_q)) ? free_idx_q : vic_idx_q;
    end
  end

  // Drop the victim and claim the new slot in one update of the valid bits.
  assign vic_mask  = evict ? (Entries'(1) << vic_idx_q) : '0;
  assign slot_mask = Entries'(1) << new_slot;

  assign old_rank = tag_rdata_i[IdxW-1:0];
  assign old_key  = tag_rdata_i[IdxW +: KeyW];

  always_comb begin
    if (!touch_q || (old_rank < hit_rank_q)) begin
      upd_rank = old_rank + IdxW'(1);
    end else begin
      upd_rank = old_rank;
    end
  end

  assign tag_raddr_o = rd_idx_q;
  assign tag_waddr_o = cmp_idx_q;
  assign tag_we_o    = updating && ((cmp_idx_q == slot_q) || valid_q[cmp_idx_q]);
  assign tag_wdata_o = (cmp_idx_q == slot_q) ? {key_q, IdxW'(0)} : {old_key, upd_rank};
  assign val_wdata_o = data_q;
  assign val_raddr_o = hit_idx_q;

  always_comb begin
    res_o.hit        = hit_q;
    res_o.read_value = ((kind_q == KIND_GET) && hit_q) ? val_rdata_i : '0;
    res_o.status     = zero_put_q ? STATUS_INVALID : STATUS_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    tag_re_o    = 1'b0;
    val_re_o    = 1'b0;
    val_we_o    = 1'b0;
    val_waddr_o = hit_idx_q;
    res_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if ((req_kind_i == KIND_PUT) && (req_data_i == '0)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        tag_re_o = 1'b1;
        if (rd_idx_q == LastIdx) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (kind_q == KIND_GET) begin
          if (hit_q) begin
            val_re_o = 1'b1;
            state_d  = ST_UPDATE;
          end else begin
            state_d = ST_FINISH;
          end
        end else begin
          val_we_o = 1'b1;
          if (!hit_q) begin
            val_waddr_o = new_slot;
          end
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        tag_re_o = 1'b1;
        if (rd_idx_q == LastIdx) begin
          state_d = ST_UPDATE_END;
        end
      end
      ST_UPDATE_END: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Scan tracking, occupancy and replacement bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      count_q    <= '0;
      rd_idx_q   <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      hit_rank_q <= '0;
      vic_q      <= 1'b0;
      vic_idx_q  <= '0;
      vic_rank_q <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      slot_q     <= '0;
      touch_q    <= 1'b0;
      zero_put_q <= 1'b0;
      kind_q     <= KIND_GET;
    end else begin
      cmp_vld_q <= issue;
      cmp_idx_q <= rd_idx_q;
      if (issue) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
      if (accept) begin
        kind_q     <= req_kind_i;
        zero_put_q <= (req_kind_i == KIND_PUT) && (req_data_i == '0);
        hit_q      <= 1'b0;
        vic_q      <= 1'b0;
        free_q     <= 1'b0;
        rd_idx_q   <= '0;
      end
      if (scanning) begin
        if (valid_q[cmp_idx_q]) begin
          if (old_key == key_q) begin
            hit_q      <= 1'b1;
            hit_idx_q  <= cmp_idx_q;
            hit_rank_q <= old_rank;
          end
          if (!vic_q || (old_rank > vic_rank_q)) begin
            vic_q      <= 1'b1;
            vic_idx_q  <= cmp_idx_q;
            vic_rank_q <= old_rank;
          end
        end else if (!free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= cmp_idx_q;
        end
      end
      if (state_q == ST_DECIDE) begin
        rd_idx_q <= '0;
        touch_q  <= hit_q;
        slot_q   <= hit_q ? hit_idx_q : new_slot;
        if ((kind_q == KIND_PUT) && !hit_q) begin
          valid_q <= (valid_q & ~vic_mask) | slot_mask;
          count_q <= evict ? count_q : count_q + CntW'(1);
        end
      end
    end
  end

  // Item payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= req_key_i;
      data_q <= req_data_i;
    end
  end

endmodule

### design/lkvc_out.sv
// Output register stage for the response channel.
// Depends on lkvc_pkg and lkvc_rsp_if.
module lkvc_out import lkvc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  lkvc_result_t  res_i,
  lkvc_rsp_if.source    out_if
);

  logic         valid_q;
  lkvc_result_t data_q;

  assign res_ready_o = !valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_if.valid      = valid_q;
  assign out_if.hit        = data_q.hit;
  assign out_if.read_value = data_q.read_value;
  assign out_if.status     = data_q.status;

endmodule

### design/lru_key_value_cache.sv
// Fully associative key/value cache with LRU replacement (top level).
// Depends on lkvc_pkg, lkvc_intf, lkvc_ram, lkvc_ctrl, lkvc_out.
//
// Usage: in_if carries one get (kind 0) or put (kind 1) item with key_tag and
// data_word; out_if returns exactly one result (hit, read_value, status) per
// item, in order. cfg_we_i/cfg_wdata_i write capacity_limit while idle.
// Keys with their recency ranks sit in one RAM, values in a second RAM.
// Every item but a zero-valued put scans the tag RAM, one entry a cycle.
// A get miss then goes to the result; a hit or a put adds a rank rewrite
// pass over the tag RAM before the result.
// A zero-valued put goes from accept straight to the finish state, with no
// scan. One item is in flight at a time; the next is accepted once the
// result is in the output register, so the scan and rewrite passes set the
// throughput.
// Reset empties the cache (valid bits and count cleared in flip-flops, no
// clearing pass) and sets capacity_limit to 16. When the receiver stalls the
// result holds in the output register; a second result then waits in the
// sequencer and input is held off until the output register frees up.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned Entries = DefEntries
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  lkvc_req_if.sink        in_if,
  lkvc_rsp_if.source      out_if
);

  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned TagW = KeyW + IdxW;

  logic            tag_we;
  logic [IdxW-1:0] tag_waddr;
  logic [TagW-1:0] tag_wdata;
  logic            tag_re;
  logic [IdxW-1:0] tag_raddr;
  logic [TagW-1:0] tag_rdata;

  logic             val_we;
  logic [IdxW-1:0]  val_waddr;
  logic [DataW-1:0] val_wdata;
  logic             val_re;
  logic [IdxW-1:0]  val_raddr;
  logic [DataW-1:0] val_rdata;

  logic         res_valid;
  logic         res_ready;
  lkvc_result_t res;

  lkvc_ram #(
    .Width (TagW),
    .Depth (Entries)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (tag_waddr),
    .wdata_i (tag_wdata),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (tag_rdata)
  );

  lkvc_ram #(
    .Width (DataW),
    .Depth (Entries)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .re_i    (val_re),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  lkvc_ctrl #(
    .Entries (Entries)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_valid_i (in_if.valid),
    .req_ready_o (in_if.ready),
    .req_kind_i  (in_if.kind),
    .req_key_i   (in_if.key_tag),
    .req_data_i  (in_if.data_word),
    .tag_we_o    (tag_we),
    .tag_waddr_o (tag_waddr),
    .tag_wdata_o (tag_wdata),
    .tag_re_o    (tag_re),
    .tag_raddr_o (tag_raddr),
    .tag_rdata_i (tag_rdata),
    .val_we_o    (val_we),
    .val_waddr_o (val_waddr),
    .val_wdata_o (val_wdata),
    .val_re_o    (val_re),
    .val_raddr_o (val_raddr),
    .val_rdata_i (val_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  lkvc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_if      (out_if)
  );

endmodule

### design/lkvc_checker.sv
// Port-level checker for the cache, bound to the top level.
// Depends on lkvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lkvc_checker import lkvc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_hit_i,
  input logic [DataW-1:0] out_read_value_i,
  input logic             out_status_i
);

  // A stalled result keeps its value.
  `LKVC_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_read_value_i))
  // A rejected put reports neither hit nor value.
  `LKVC_ASSERT(a_invalid_clean, clk_i, rst_ni, out_valid_i && out_status_i |-> !out_hit_i && out_read_value_i == '0)
  // Stored values are never zero, so a nonzero value only comes from a hit.
  `LKVC_ASSERT(a_value_needs_hit, clk_i, rst_ni, out_valid_i && out_read_value_i != '0 |-> out_hit_i)
  // One item in flight: input closes right after an accept.
  `LKVC_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i)
  `LKVC_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i)

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_if.valid),
  .in_ready_i       (in_if.ready),
  .out_valid_i      (out_if.valid),
  .out_ready_i      (out_if.ready),
  .out_hit_i        (out_if.hit),
  .out_read_value_i (out_if.read_value),
  .out_status_i     (out_if.status)
);

### sim/tb_top.sv
// Self-checking testbench for lru_key_value_cache: gets and puts with random gaps and
// stalls, capacity changes between phases, every result checked against an LRU model.
// Depends on lkvc_pkg, lkvc_intf and lru_key_value_cache from the design folder.
`timescale 1ns / 100ps

module tb_top;
  import lkvc_pkg::*;

  localparam int unsigned Lines     = DefEntries;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned MaxShown  = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CapW-1:0] cfg_wdata;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();

  lru_key_value_cache dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (req_if),
    .out_if      (rsp_if)
  );

  always #6 clk = ~clk;

  // Cache model state
  logic [KeyW-1:0]  line_key [Lines];
  logic [DataW-1:0] line_val [Lines];
  bit               line_vld [Lines];
  int unsigned      line_age [Lines];
  int unsigned      line_cnt;
  logic [CapW-1:0]  cap_reg;

  lkvc_result_t     due_replies [$];
  logic [KeyW-1:0]  key_pool [$];

  bit          gaps_on = 1'b1;
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_gets = 0, n_puts = 0, n_rejects = 0;
  int unsigned n_hits = 0, n_evicts = 0, n_settings = 0;

  function automatic int find_line(logic [KeyW-1:0] key);
    for (int i = 0; i < Lines; i++)
      if (line_vld[i] && line_key[i] == key) return i;
    return -1;
  endfunction

  // Make a line most recent; lines that were more recent age by one.
  function automatic void promote(int s);
    int unsigned r;
    r = line_age[s];
    for (int i = 0; i < Lines; i++)
      if (line_vld[i] && i != s && line_age[i] < r) line_age[i]++;
    line_age[s] = 0;
  endfunction

  function automatic lkvc_result_t lru_access(lkvc_kind_e op, logic [KeyW-1:0] key,
                                              logic [DataW-1:0] word);
    lkvc_result_t res;
    int slot;
    int victim;
    int unsigned cap;
    res = '0;
    res.status = STATUS_OK;
    if (op == KIND_PUT && word == '0) begin
      res.status = STATUS_INVALID;
      n_rejects++;
      return res;
    end
    slot = find_line(key);
    if (slot >= 0) begin
      res.hit = 1'b1;
      n_hits++;
      if (op == KIND_GET) res.read_value = line_val[slot];
      else line_val[slot] = word;
      promote(slot);
    end else if (op == KIND_PUT) begin
      cap = (cap_reg < MinCap) ? MinCap : (cap_reg > Lines) ? Lines : cap_reg;
      // Only one victim per insert, even when the capacity was lowered below the count.
      if (line_cnt >= cap) begin
        victim = -1;
        for (int i = 0; i < Lines; i++)
          if (line_vld[i] && (victim < 0 || line_age[i] > line_age[victim])) victim = i;
        if (victim >= 0) begin
          line_vld[victim] = 1'b0;
          line_cnt--;
          n_evicts++;
        end
      end
      slot = -1;
      for (int i = 0; i < Lines; i++)
        if (!line_vld[i] && slot < 0) slot = i;
      if (slot >= 0) begin
        for (int i = 0; i < Lines; i++)
          if (line_vld[i]) line_age[i]++;
        line_key[slot] = key;
        line_val[slot] = word;
        line_vld[slot] = 1'b1;
        line_age[slot] = 0;
        line_cnt++;
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DataW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return '1;
    if (r < 20) return DataW'(1) << $urandom_range(0, DataW - 1);
    return {$urandom, $urandom};
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxShown) $display("%0t ns mismatch: %s", $time, msg);
  endfunction

  task automatic send_req(lkvc_kind_e op, logic [KeyW-1:0] key, logic [DataW-1:0] word);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      // Idle with junk on the payload.
      req_if.valid     <= 1'b0;
      req_if.kind      <= 1'($urandom_range(0, 1));
      req_if.key_tag   <= {$urandom, $urandom};
      req_if.data_word <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= op;
    req_if.key_tag   <= key;
    req_if.data_word <= word;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (op == KIND_GET) n_gets++;
    else n_puts++;
    due_replies.push_back(lru_access(op, key, word));
  endtask

  task automatic drain();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CapW-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_reg = v;
    n_settings++;
  endtask

  // Mostly keys from a small pool so that hits, updates and evictions are frequent.
  task automatic run_traffic(int unsigned n, int unsigned pool_size, int unsigned put_pct);
    logic [KeyW-1:0] key;
    lkvc_kind_e op;
    key_pool.delete();
    for (int i = 0; i < pool_size; i++) key_pool.push_back({$urandom, $urandom});
    if ($urandom_range(0, 1)) key_pool[0] = '0;
    if ($urandom_range(0, 1)) key_pool[1] = '1;
    repeat (n) begin
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
      else key = {$urandom, $urandom};
      op = ($urandom_range(0, 99) < put_pct) ? KIND_PUT : KIND_GET;
      send_req(op, key, (op == KIND_PUT) ? pick_word() : {$urandom, $urandom});
    end
  endtask

  task automatic test_basic_ops();
    send_req(KIND_GET, '0, '0);
    send_req(KIND_PUT, '0, '0);
    send_req(KIND_PUT, '0, '1);
    send_req(KIND_GET, '0, '0);
    send_req(KIND_PUT, '1, 64'd1);
    send_req(KIND_PUT, '1, 64'h8000_0000_0000_0000);
    send_req(KIND_GET, '1, '1);
    send_req(KIND_PUT, '0, '0);
    send_req(KIND_GET, '0, 64'h5555_aaaa_5555_aaaa);
    send_req(KIND_GET, 64'h0123_4567_89ab_cdef, '1);
  endtask

  // Register 0 clamps to eight lines; overflow, then read back the oldest keys and the newest one.
  task automatic test_clamped_minimum();
    set_capacity('0);
    for (int i = 1; i <= 9; i++)
      send_req(KIND_PUT, 64'h0101_0101_0101_0101 * i, 64'hf0f0_0000_0000_0000 + i);
    send_req(KIND_GET, '1, '0);
    send_req(KIND_GET, '0, '0);
    send_req(KIND_GET, 64'h0101_0101_0101_0101 * 9, '0);
  endtask

  task automatic test_random_mix();
    logic [CapW-1:0] caps [5];
    caps = '{5'd16, 5'd31, 5'd12, 5'd17, CapW'($urandom_range(0, 31))};
    foreach (caps[i]) begin
      set_capacity(caps[i]);
      run_traffic(120, $urandom_range(10, 24), 50);
    end
  endtask

  // Fill all lines, then drop the capacity below the count.
  task automatic test_capacity_shrink();
    set_capacity(5'd16);
    run_traffic(60, 24, 85);
    set_capacity(5'd7);
    run_traffic(100, 20, 50);
    set_capacity(5'd8);
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    set_capacity(CapW'($urandom_range(0, 31)));
    run_traffic(110, 18, 50);
    gaps_on = 1'b1;
  endtask

  // Receiver: random stalls between runs of ready.
  always @(negedge clk) begin : rsp_stall
    int unsigned stall_left;
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : reply_check
    lkvc_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (due_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected result hit %0b value %h status %0b",
                                rsp_if.hit, rsp_if.read_value, rsp_if.status));
      end else begin
        want = due_replies.pop_front();
        if (rsp_if.hit !== want.hit || rsp_if.read_value !== want.read_value ||
            rsp_if.status !== want.status)
          note_mismatch($sformatf("expected hit %0b value %h status %0b, got %0b %h %0b",
                                  want.hit, want.read_value, want.status,
                                  rsp_if.hit, rsp_if.read_value, rsp_if.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", IdleLimit);
      $display("** lru_key_value_cache: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    req_if.valid     = 1'b0;
    req_if.kind      = KIND_GET;
    req_if.key_tag   = '0;
    req_if.data_word = '0;
    rsp_if.ready     = 1'b0;
    foreach (line_vld[i]) line_vld[i] = 1'b0;
    line_cnt = 0;
    cap_reg  = CapReset;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_clamped_minimum();
    test_random_mix();
    test_capacity_shrink();
    test_back_to_back();

    drain();
    repeat (2 * Lines + 8) @(posedge clk);
    $display("Ran %0d gets and %0d puts (%0d zero-value), %0d hits, %0d evictions,",
             n_gets, n_puts, n_rejects, n_hits, n_evicts);
    $display("over %0d capacity settings; %0d mismatches, %0d results missing",
             n_settings, mismatch_cnt, due_replies.size());
    if (mismatch_cnt == 0 && due_replies.size() == 0) begin
      $display("** lru_key_value_cache: PASSED **");
    end else begin
      $display("** lru_key_value_cache: FAILED **");
    end
    $finish;
  end

endmodule
